// ===== sv/tea_block_cipher_unit_assert.svh =====
// Assertion macros for the TEA cipher unit.
// No dependencies; included by files that assert.
`ifndef TEA_BLOCK_CIPHER_UNIT_ASSERT_SVH
`define TEA_BLOCK_CIPHER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TEA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tea assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TEA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tea assertion failed");

`endif

// ===== sv/tea_pkg.sv =====
// Shared types and constants of the TEA cipher unit.
// No dependencies.
package tea_pkg;

   localparam int unsigned WordWidth     = 32;
   localparam int unsigned RoundCount    = 32;
   localparam int unsigned StageCount    = 2 * RoundCount;
   localparam int unsigned CsrIndexWidth = 3;
   localparam logic [WordWidth-1:0] Delta = 32'h9E37_79B9;

   // Register indexes of the configuration port
   localparam logic [CsrIndexWidth-1:0] CsrKeyWord0 = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrKeyWord1 = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrKeyWord2 = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrKeyWord3 = 3'd3;

   // Command codes
   localparam logic CmdEncrypt = 1'b0;
   localparam logic CmdDecrypt = 1'b1;

   typedef struct packed {
      logic [WordWidth-1:0] k0;
      logic [WordWidth-1:0] k1;
      logic [WordWidth-1:0] k2;
      logic [WordWidth-1:0] k3;
   } tea_key_type;

   typedef struct packed {
      logic                 decrypt;
      logic [WordWidth-1:0] left;
      logic [WordWidth-1:0] right;
      logic                 last;
   } tea_item_type;

   // Round sum mult*Delta mod 2^32; only called with elaboration constants.
   function automatic logic [WordWidth-1:0] round_sum(int unsigned mult);
      logic [2*WordWidth-1:0] prod;
      prod = (2*WordWidth)'(Delta) * (2*WordWidth)'(mult);
      return prod[WordWidth-1:0];
   endfunction

endpackage

// ===== sv/tea_chan_if.sv =====
// Valid/ready channel interfaces of the TEA cipher unit.
// Depends on tea_pkg for word widths.
interface tea_req_if;
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic [tea_pkg::WordWidth-1:0] block_left;
   logic [tea_pkg::WordWidth-1:0] block_right;
   logic                          last_block;

   modport source (output valid, command, block_left, block_right, last_block,
                   input ready);
   modport sink   (input valid, command, block_left, block_right, last_block,
                   output ready);
endinterface

interface tea_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tea_pkg::WordWidth-1:0] out_left;
   logic [tea_pkg::WordWidth-1:0] out_right;
   logic                          out_last;

   modport source (output valid, out_left, out_right, out_last, input ready);
   modport sink   (input valid, out_left, out_right, out_last, output ready);
endinterface

// ===== sv/tea_block_cipher_unit.sv =====
// TEA block cipher unit: 64-bit blocks, 128-bit key in four 32-bit registers
// (csr index 0..3, other indexes ignored). The cipher is fully unrolled into
// 64 pipeline stages, one half-round each, so one item is accepted every clock
// while the result output is not stalled. Encrypt and decrypt items may be
// mixed freely. A stalled result stalls only the full stages behind it with no
// empty stage between; empty stages keep filling. Keys are read live by every
// stage, so write them only while the pipeline is empty.
// Depends on tea_pkg, tea_chan_if, tea_half_round and the assertion header.
`include "tea_block_cipher_unit_assert.svh"

module tea_block_cipher_unit (
   input  logic                              clock,
   input  logic                              reset,
   tea_req_if.sink                           req_chan,
   tea_rsp_if.source                         rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [tea_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [tea_pkg::WordWidth-1:0]     csr_write_data
);
   import tea_pkg::*;

   tea_key_type             key_ff;
   tea_item_type            req_item;
   logic [StageCount-1:0]   stage_valid;
   logic [StageCount-1:0]   advance;
   tea_item_type            stage_item [StageCount];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CsrKeyWord0: key_ff.k0 <= csr_write_data;
            CsrKeyWord1: key_ff.k1 <= csr_write_data;
            CsrKeyWord2: key_ff.k2 <= csr_write_data;
            CsrKeyWord3: key_ff.k3 <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign req_item.decrypt = req_chan.command;
   assign req_item.left    = req_chan.block_left;
   assign req_item.right   = req_chan.block_right;
   assign req_item.last    = req_chan.last_block;

   for (genvar j = 0; j < StageCount; j++) begin : g_stage
      // a stage moves when it is empty or the one ahead moves
      if (j == StageCount - 1) begin : g_tail
         assign advance[j] = !stage_valid[j] || rsp_chan.ready;
      end else begin : g_body
         assign advance[j] = !stage_valid[j] || advance[j+1];
      end

      if (j == 0) begin : g_head
         tea_half_round u_round (
            .clock     (clock),
            .reset     (reset),
            .advance   (advance[j]),
            .odd_stage (1'b0),
            .enc_sum   (round_sum(1)),
            .dec_sum   (round_sum(RoundCount)),
            .key       (key_ff),
            .in_valid  (req_chan.valid),
            .in_item   (req_item),
            .out_valid (stage_valid[j]),
            .out_item  (stage_item[j])
         );
      end else begin : g_next
         tea_half_round u_round (
            .clock     (clock),
            .reset     (reset),
            .advance   (advance[j]),
            .odd_stage ((j % 2) == 1),
            .enc_sum   (round_sum(j / 2 + 1)),
            .dec_sum   (round_sum(RoundCount - j / 2)),
            .key       (key_ff),
            .in_valid  (stage_valid[j-1]),
            .in_item   (stage_item[j-1]),
            .out_valid (stage_valid[j]),
            .out_item  (stage_item[j])
         );
      end
   end

   assign req_chan.ready     = advance[0];
   assign rsp_chan.valid     = stage_valid[StageCount-1];
   assign rsp_chan.out_left  = stage_item[StageCount-1].left;
   assign rsp_chan.out_right = stage_item[StageCount-1].right;
   assign rsp_chan.out_last  = stage_item[StageCount-1].last;

   `TEA_ASSERT_NOW(a_full_when_blocked, clock, reset, !req_chan.ready, (&stage_valid) && !rsp_chan.ready)
   `TEA_ASSERT_NEXT(a_accept_fills_head, clock, reset, req_chan.valid && req_chan.ready, stage_valid[0])
   `TEA_ASSERT_NOW(a_reset_empties, clock, 1'b0, $past(reset), stage_valid == '0)

endmodule

// ===== sv/tea_half_round.sv =====
// One registered pipeline stage of the TEA cipher: a single half-round.
// Depends on tea_pkg.
module tea_half_round (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          odd_stage,
   input  logic [tea_pkg::WordWidth-1:0] enc_sum,
   input  logic [tea_pkg::WordWidth-1:0] dec_sum,
   input  tea_pkg::tea_key_type          key,
   input  logic                          in_valid,
   input  tea_pkg::tea_item_type         in_item,
   output logic                          out_valid,
   output tea_pkg::tea_item_type         out_item
);
   import tea_pkg::*;

   logic                 valid_ff;
   tea_item_type         item_ff;
   tea_item_type         item_in;
   logic                 update_left;
   logic [WordWidth-1:0] src;
   logic [WordWidth-1:0] sum;
   logic [WordWidth-1:0] ka;
   logic [WordWidth-1:0] kb;
   logic [WordWidth-1:0] mix;
   logic [WordWidth-1:0] target;
   logic [WordWidth-1:0] result;

   // Encrypt: even stage updates left, odd updates right; decrypt the reverse.
   assign update_left = (in_item.decrypt == CmdDecrypt) ? odd_stage : !odd_stage;
   assign sum    = (in_item.decrypt == CmdDecrypt) ? dec_sum : enc_sum;
   assign src    = update_left ? in_item.right : in_item.left;
   assign target = update_left ? in_item.left  : in_item.right;
   assign ka     = update_left ? key.k0 : key.k2;
   assign kb     = update_left ? key.k1 : key.k3;

   assign mix = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
   assign result = (in_item.decrypt == CmdDecrypt) ? target - mix : target + mix;

   always_comb begin
      item_in = in_item;
      if (update_left) begin
         item_in.left = result;
      end else begin
         item_in.right = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule
